### hdl/hbqd_pkg.sv
// Shared types, constants and the distance lookup table for the HSV bin quantizer.
package hbqd_pkg;

    localparam int HUE_BYTE_W   = 8;
    localparam int HUE_BIN_W    = 5;
    localparam int SV_BIN_W     = 2;
    localparam int DH_W         = 4;
    localparam int BIN_W        = HUE_BIN_W + 2 * SV_BIN_W;
    localparam int DIST_W       = 15;
    localparam int LUT_IDX_W    = DH_W + 2 * SV_BIN_W;
    localparam int LUT_DEPTH    = 1 << LUT_IDX_W;

    localparam logic [9:0] HUE_FULL_TURN = 10'd360;
    localparam logic [9:0] HUE_HALF_STEP = 10'd9;
    // 3641 / 65536 approximates 1/18 closely enough for every value below 360.
    localparam logic [11:0] DIV18_RECIP  = 12'd3641;
    localparam int          DIV18_SHIFT  = 16;

    localparam logic [HUE_BIN_W-1:0] GRAY_BIN      = 5'd20;
    localparam logic [HUE_BIN_W-1:0] HUE_BINS      = 5'd20;
    localparam logic [HUE_BIN_W-1:0] HUE_HALF_BINS = 5'd10;
    localparam logic [7:0]           GRAY_SAT_LIMIT = 8'd10;
    localparam logic [DH_W-1:0]      DH_SCALE_LIMIT = 4'd3;

    localparam logic [7:0] MARK_HUE = 8'd8;
    localparam logic [7:0] MARK_SAT = 8'd64;
    localparam logic [7:0] MARK_VAL = 8'd64;

    localparam longint unsigned DIST_DEN = 64'd1350;

    // One classified pixel pair, passed from the front end to the back end.
    typedef struct packed {
        logic [BIN_W-1:0]    bin_a;
        logic [BIN_W-1:0]    bin_b;
        logic [DH_W-1:0]     dh;
        logic [SV_BIN_W-1:0] ds;
        logic [SV_BIN_W-1:0] dv;
        logic                ignore_a;
        logic                ignore_b;
    } t_item;

    typedef logic [DIST_W-1:0] t_dist_lut [LUT_DEPTH];

    // Largest q with (2q-1)^2 * 1350 <= 2^30 * s, which is the rounded
    // value of 16384 * sqrt(s / 1350).
    function automatic logic [DIST_W-1:0] scaled_root(input longint unsigned s);
        longint unsigned n;
        longint unsigned q;
        longint unsigned t;
        longint unsigned k;
        n = s << 30;
        q = 0;
        for (int b = 15; b >= 0; b--) begin
            t = q | (64'd1 << b);
            k = 2 * t - 1;
            if (k * k * DIST_DEN <= n) begin
                q = t;
            end
        end
        return q[DIST_W-1:0];
    endfunction

    // Index is {dh, ds, dv}; hue differences above ten never occur.
    function automatic t_dist_lut build_dist_lut();
        t_dist_lut       lut;
        longint unsigned dh;
        longint unsigned ds;
        longint unsigned dv;
        longint unsigned s;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            dh = longint'(i) >> (2 * SV_BIN_W);
            ds = (longint'(i) >> SV_BIN_W) & 64'd3;
            dv = longint'(i) & 64'd3;
            s  = ((dh < 3) ? 64'd9 : 64'd25) * dh * dh + 64'd25 * (ds * ds + dv * dv);
            lut[i] = scaled_root(s);
        end
        return lut;
    endfunction

    localparam t_dist_lut DIST_LUT = build_dist_lut();

endpackage

### hdl/hsv_bin_quantize_distance_core.sv
// Top level of the HSV bin quantizer and bin distance block.
// Usage: the block takes a pair of HSV pixels (raw bytes, hue in two-degree
// steps) and returns both bin indexes, the normalized bin distance in 1.14
// fixed point, and a don't-care flag for each pixel.
// The input side looks like a queue: a transfer happens at a rising clock edge
// where push is high and full is low. The result side also looks like a queue:
// while empty is low the oldest result is on the o_ ports, and a transfer
// happens at an edge where pop is high and empty is low.
// An input transfer loads the quantized pair into the front-end register,
// which writes it into the queue; the distance lookup from the queue head
// fills the output register, and empty goes low. Throughput is one pixel pair
// per cycle while the consumer keeps popping: the front-end and output
// registers take a new item in the same cycle that they hand one on.
// When the consumer stalls, results collect in the output register and the
// queue of QUEUE_DEPTH entries, then in the front-end register; full rises
// only once all of these are occupied.
// Reset (synchronous, active low) empties the pipeline; no item survives it.
module hsv_bin_quantize_distance_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_hue_a,
    input  logic [7:0]                  i_sat_a,
    input  logic [7:0]                  i_val_a,
    input  logic [7:0]                  i_hue_b,
    input  logic [7:0]                  i_sat_b,
    input  logic [7:0]                  i_val_b,
    output logic                        empty,
    input  logic                        pop,
    output logic [hbqd_pkg::BIN_W-1:0]  o_bin_a,
    output logic [hbqd_pkg::BIN_W-1:0]  o_bin_b,
    output logic [hbqd_pkg::DIST_W-1:0] o_distance_q,
    output logic                        o_ignore_a,
    output logic                        o_ignore_b
);

    // Classified item leaving the front end, and the one at the queue head.
    hbqd_pkg::t_item front_item;
    hbqd_pkg::t_item head_item;
    logic            front_valid;
    logic            q_full;
    logic            q_empty;
    logic            back_take;

    // The front end quantizes hue, saturation and value and reduces the pair
    // to the three bin differences the distance depends on.
    hbqd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_hue_a  (i_hue_a),
        .i_sat_a  (i_sat_a),
        .i_val_a  (i_val_a),
        .i_hue_b  (i_hue_b),
        .i_sat_b  (i_sat_b),
        .i_val_b  (i_val_b),
        .o_valid  (front_valid),
        .o_item   (front_item),
        .i_q_full (q_full)
    );

    // The queue lets the front end keep accepting while the consumer stalls.
    hbqd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_rd    (back_take),
        .o_item  (head_item),
        .o_empty (q_empty)
    );

    // The back end turns the bin differences into the distance by a constant
    // table and presents the finished result.
    hbqd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_item       (head_item),
        .o_take       (back_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_bin_a      (o_bin_a),
        .o_bin_b      (o_bin_b),
        .o_distance_q (o_distance_q),
        .o_ignore_a   (o_ignore_a),
        .o_ignore_b   (o_ignore_b)
    );

endmodule

### hdl/hbqd_front.sv
// Front end: quantizes both pixels, forms bin differences and flags, one register stage.
module hbqd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [7:0]            i_hue_a,
    input  logic [7:0]            i_sat_a,
    input  logic [7:0]            i_val_a,
    input  logic [7:0]            i_hue_b,
    input  logic [7:0]            i_sat_b,
    input  logic [7:0]            i_val_b,
    output logic                  o_valid,
    output hbqd_pkg::t_item       o_item,
    input  logic                  i_q_full
);

    logic            r_valid;
    hbqd_pkg::t_item r_item;
    hbqd_pkg::t_item n_item;
    logic            load;
    logic            drain;

    logic [hbqd_pkg::HUE_BIN_W-1:0] hb_a, hb_b;
    logic [hbqd_pkg::SV_BIN_W-1:0]  sb_a, sb_b, vb_a, vb_b;
    logic                           gray_a, gray_b;
    logic [hbqd_pkg::HUE_BIN_W-1:0] d_hue;
    logic [hbqd_pkg::HUE_BIN_W-1:0] d_circ;
    logic [hbqd_pkg::SV_BIN_W-1:0]  v_max;

    function automatic logic [hbqd_pkg::HUE_BIN_W-1:0] hue_bin(input logic [7:0] h);
        logic [9:0]  x;
        logic [9:0]  m;
        logic [21:0] p;
        x = {1'b0, h, 1'b0} + hbqd_pkg::HUE_HALF_STEP;
        m = (x >= hbqd_pkg::HUE_FULL_TURN) ? x - hbqd_pkg::HUE_FULL_TURN : x;
        p = {12'd0, m} * {10'd0, hbqd_pkg::DIV18_RECIP};
        return p[hbqd_pkg::DIV18_SHIFT +: hbqd_pkg::HUE_BIN_W];
    endfunction

    assign gray_a = i_sat_a < hbqd_pkg::GRAY_SAT_LIMIT;
    assign gray_b = i_sat_b < hbqd_pkg::GRAY_SAT_LIMIT;
    assign hb_a   = gray_a ? hbqd_pkg::GRAY_BIN : hue_bin(i_hue_a);
    assign hb_b   = gray_b ? hbqd_pkg::GRAY_BIN : hue_bin(i_hue_b);
    assign sb_a   = i_sat_a[7:6];
    assign sb_b   = i_sat_b[7:6];
    assign vb_a   = i_val_a[7:6];
    assign vb_b   = i_val_b[7:6];

    always_comb begin
        d_hue  = (hb_a > hb_b) ? hb_a - hb_b : hb_b - hb_a;
        d_circ = (d_hue < hbqd_pkg::HUE_HALF_BINS) ? d_hue : hbqd_pkg::HUE_BINS - d_hue;
        v_max  = (vb_a > vb_b) ? vb_a : vb_b;

        n_item.bin_a = {hb_a, sb_a, vb_a};
        n_item.bin_b = {hb_b, sb_b, vb_b};
        // With exactly one gray pixel the hue term is the larger value bin.
        n_item.dh    = (gray_a != gray_b) ? {2'b00, v_max} : d_circ[hbqd_pkg::DH_W-1:0];
        n_item.ds    = (sb_a > sb_b) ? sb_a - sb_b : sb_b - sb_a;
        n_item.dv    = (vb_a > vb_b) ? vb_a - vb_b : vb_b - vb_a;
        n_item.ignore_a = (i_hue_a == hbqd_pkg::MARK_HUE) && (i_sat_a == hbqd_pkg::MARK_SAT)
                          && (i_val_a == hbqd_pkg::MARK_VAL);
        n_item.ignore_b = (i_hue_b == hbqd_pkg::MARK_HUE) && (i_sat_b == hbqd_pkg::MARK_SAT)
                          && (i_val_b == hbqd_pkg::MARK_VAL);
    end

    assign drain  = r_valid && !i_q_full;
    assign o_full = r_valid && i_q_full;
    assign load   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = drain;
    assign o_item  = r_item;

endmodule

### hdl/hbqd_fifo.sv
// Short queue of classified items between the front end and the back end.
module hbqd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  hbqd_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_rd,
    output hbqd_pkg::t_item o_item,
    output logic            o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    hbqd_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            wr_en, rd_en;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_item  = r_mem[r_rptr];

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= bump(r_wptr);
            end
            if (rd_en) begin
                r_rptr <= bump(r_rptr);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

### hdl/hbqd_back.sv
// Back end: looks up the distance for a classified item and holds the result for the consumer.
module hbqd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  hbqd_pkg::t_item             i_item,
    output logic                        o_take,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [hbqd_pkg::BIN_W-1:0]  o_bin_a,
    output logic [hbqd_pkg::BIN_W-1:0]  o_bin_b,
    output logic [hbqd_pkg::DIST_W-1:0] o_distance_q,
    output logic                        o_ignore_a,
    output logic                        o_ignore_b
);

    logic                          r_valid;
    logic [hbqd_pkg::BIN_W-1:0]    r_bin_a, r_bin_b;
    logic [hbqd_pkg::DIST_W-1:0]   r_distance_q;
    logic                          r_ignore_a, r_ignore_b;
    logic [hbqd_pkg::LUT_IDX_W-1:0] lut_idx;

    assign lut_idx = {i_item.dh, i_item.ds, i_item.dv};
    assign o_take  = !i_q_empty && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bin_a      <= i_item.bin_a;
            r_bin_b      <= i_item.bin_b;
            r_distance_q <= hbqd_pkg::DIST_LUT[lut_idx];
            r_ignore_a   <= i_item.ignore_a;
            r_ignore_b   <= i_item.ignore_b;
        end
    end

    assign o_empty      = !r_valid;
    assign o_bin_a      = r_bin_a;
    assign o_bin_b      = r_bin_b;
    assign o_distance_q = r_distance_q;
    assign o_ignore_a   = r_ignore_a;
    assign o_ignore_b   = r_ignore_b;

endmodule

### tb/hsv_bin_quantize_distance_core_tb.sv
// Self-checking testbench for the HSV bin quantizer and bin distance core.
`timescale 1ns / 1ps

module hsv_bin_quantize_distance_core_tb;

    localparam int unsigned HUE_TURN_HALF = 360;  // full hue circle after doubling
    localparam int unsigned HUE_BIN_SPAN  = 18;   // degrees per hue bin
    localparam int unsigned SV_BIN_SPAN   = 64;   // byte codes per saturation/value bin
    localparam int unsigned DH_SOFT_LIMIT = 3;    // hue differences below this are scaled
    localparam int unsigned SOFT_WEIGHT   = 9;    // 25 * 0.6^2
    localparam int unsigned FULL_WEIGHT   = 25;
    localparam int unsigned ROOT_MAX      = (1 << hbqd_pkg::DIST_W) - 1;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;

    // One pixel pair as driven on the input ports.
    typedef struct {
        logic [7:0] hue_a;
        logic [7:0] sat_a;
        logic [7:0] val_a;
        logic [7:0] hue_b;
        logic [7:0] sat_b;
        logic [7:0] val_b;
    } t_hsv_pair;

    // One result as seen on the output ports.
    typedef struct {
        logic [hbqd_pkg::BIN_W-1:0]  bin_a;
        logic [hbqd_pkg::BIN_W-1:0]  bin_b;
        logic [hbqd_pkg::DIST_W-1:0] distance_q;
        logic                        ignore_a;
        logic                        ignore_b;
    } t_bin_result;

    // Predicts the bins and distance of each accepted pair and checks the
    // results in order against those predictions.
    class t_bin_distance_board;
        t_bin_result pending_results[$];
        int unsigned failures;
        int unsigned checked;
        int unsigned marker_pixels;
        int unsigned single_gray_pairs;
        int unsigned both_gray_pairs;

        function new();
            failures          = 0;
            checked           = 0;
            marker_pixels     = 0;
            single_gray_pairs = 0;
            both_gray_pairs   = 0;
        endfunction

        // Hue, saturation and value bins of one pixel.
        function automatic void quantize_pixel(input logic [7:0] h, input logic [7:0] s,
                                               input logic [7:0] v, output int unsigned hb,
                                               output int unsigned sb, output int unsigned vb);
            hb = ((int'(h) * 2 + HUE_BIN_SPAN / 2) % HUE_TURN_HALF) / HUE_BIN_SPAN;
            if (s < hbqd_pkg::GRAY_SAT_LIMIT) begin
                hb = hbqd_pkg::GRAY_BIN;
            end
            sb = s / SV_BIN_SPAN;
            vb = v / SV_BIN_SPAN;
        endfunction

        // Rounded 16384 * sqrt(sum / 1350), found by bisection on the largest q
        // with (2q-1)^2 * 1350 <= 2^30 * sum.
        function automatic logic [hbqd_pkg::DIST_W-1:0] rounded_root(
            input longint unsigned sum);
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            longint unsigned odd;
            lo = 0;
            hi = ROOT_MAX;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                odd = 2 * mid - 1;
                if (odd * odd * hbqd_pkg::DIST_DEN <= (sum << 30)) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            return lo[hbqd_pkg::DIST_W-1:0];
        endfunction

        function automatic t_bin_result predict_bins_distance(input t_hsv_pair p);
            t_bin_result     r;
            int unsigned     hb_a, sb_a, vb_a, hb_b, sb_b, vb_b;
            int unsigned     dhue, dh, ds, dv;
            bit              gray_a, gray_b;
            longint unsigned sum;
            quantize_pixel(p.hue_a, p.sat_a, p.val_a, hb_a, sb_a, vb_a);
            quantize_pixel(p.hue_b, p.sat_b, p.val_b, hb_b, sb_b, vb_b);
            gray_a = (hb_a == hbqd_pkg::GRAY_BIN);
            gray_b = (hb_b == hbqd_pkg::GRAY_BIN);
            dhue   = (hb_a > hb_b) ? hb_a - hb_b : hb_b - hb_a;
            dh     = (dhue < hbqd_pkg::HUE_BINS - dhue) ? dhue : hbqd_pkg::HUE_BINS - dhue;
            // A gray pixel against a colored one: the brighter value bin stands in
            // for the hue difference.
            if (gray_a != gray_b) begin
                dh = (vb_a > vb_b) ? vb_a : vb_b;
                single_gray_pairs++;
            end else if (gray_a) begin
                both_gray_pairs++;
            end
            ds  = (sb_a > sb_b) ? sb_a - sb_b : sb_b - sb_a;
            dv  = (vb_a > vb_b) ? vb_a - vb_b : vb_b - vb_a;
            sum = longint'((dh < DH_SOFT_LIMIT) ? SOFT_WEIGHT : FULL_WEIGHT) * dh * dh
                  + longint'(FULL_WEIGHT) * (ds * ds + dv * dv);
            r.bin_a      = hbqd_pkg::BIN_W'(hb_a * 16 + sb_a * 4 + vb_a);
            r.bin_b      = hbqd_pkg::BIN_W'(hb_b * 16 + sb_b * 4 + vb_b);
            r.distance_q = rounded_root(sum);
            r.ignore_a   = (p.hue_a == hbqd_pkg::MARK_HUE && p.sat_a == hbqd_pkg::MARK_SAT
                            && p.val_a == hbqd_pkg::MARK_VAL);
            r.ignore_b   = (p.hue_b == hbqd_pkg::MARK_HUE && p.sat_b == hbqd_pkg::MARK_SAT
                            && p.val_b == hbqd_pkg::MARK_VAL);
            marker_pixels += r.ignore_a + r.ignore_b;
            return r;
        endfunction

        function void note_pair(input t_hsv_pair p);
            pending_results.push_back(predict_bins_distance(p));
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(input t_bin_result got);
            t_bin_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got bins %0d/%0d distance %0d",
                         $time, got.bin_a, got.bin_b, got.distance_q);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("bin_a", want.bin_a, got.bin_a);
            compare_field("bin_b", want.bin_b, got.bin_b);
            compare_field("distance_q", want.distance_q, got.distance_q);
            compare_field("ignore_a", want.ignore_a, got.ignore_a);
            compare_field("ignore_b", want.ignore_b, got.ignore_b);
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          push    = 1'b0;
    logic                          pop     = 1'b0;
    logic [7:0]                    i_hue_a = '0;
    logic [7:0]                    i_sat_a = '0;
    logic [7:0]                    i_val_a = '0;
    logic [7:0]                    i_hue_b = '0;
    logic [7:0]                    i_sat_b = '0;
    logic [7:0]                    i_val_b = '0;
    logic                          full;
    logic                          empty;
    logic [hbqd_pkg::BIN_W-1:0]    o_bin_a;
    logic [hbqd_pkg::BIN_W-1:0]    o_bin_b;
    logic [hbqd_pkg::DIST_W-1:0]   o_distance_q;
    logic                          o_ignore_a;
    logic                          o_ignore_b;

    // Idle percentages for each side; the main sequence changes them per phase.
    int unsigned         tx_idle_pct = 0;
    int unsigned         rx_idle_pct = 0;
    int unsigned         pairs_sent  = 0;
    int unsigned         quiet_cycles = 0;

    t_bin_distance_board board = new();

    hsv_bin_quantize_distance_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_hue_a      (i_hue_a),
        .i_sat_a      (i_sat_a),
        .i_val_a      (i_val_a),
        .i_hue_b      (i_hue_b),
        .i_sat_b      (i_sat_b),
        .i_val_b      (i_val_b),
        .empty        (empty),
        .pop          (pop),
        .o_bin_a      (o_bin_a),
        .o_bin_b      (o_bin_b),
        .o_distance_q (o_distance_q),
        .o_ignore_a   (o_ignore_a),
        .o_ignore_b   (o_ignore_b)
    );

    always #5 i_clk = ~i_clk;

    // Result side. Values read right at the edge are the ones from before it,
    // so pop and empty here describe exactly the transfer the block saw. The
    // pop decision for the next cycle is made once per edge.
    always @(posedge i_clk) begin
        t_bin_result got;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.bin_a      = o_bin_a;
                got.bin_b      = o_bin_b;
                got.distance_q = o_distance_q;
                got.ignore_a   = o_ignore_a;
                got.ignore_b   = o_ignore_b;
                board.check_result(got);
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means the
    // block has hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_hsv_pair make_pair(input logic [7:0] ha, input logic [7:0] sa,
                                            input logic [7:0] va, input logic [7:0] hb,
                                            input logic [7:0] sb, input logic [7:0] vb);
        t_hsv_pair p;
        p.hue_a = ha;
        p.sat_a = sa;
        p.val_a = va;
        p.hue_b = hb;
        p.sat_b = sb;
        p.val_b = vb;
        return p;
    endfunction

    // Random pixel, biased toward the gray threshold, the hue wrap point and
    // the don't-care marker and its near misses.
    function automatic void random_pixel(output logic [7:0] h, output logic [7:0] s,
                                         output logic [7:0] v);
        int unsigned pick;
        pick = $urandom_range(99);
        h    = 8'($urandom);
        s    = 8'($urandom);
        v    = 8'($urandom);
        if (pick < 8) begin
            h = hbqd_pkg::MARK_HUE;
            s = hbqd_pkg::MARK_SAT;
            v = hbqd_pkg::MARK_VAL;
        end else if (pick < 14) begin
            h = hbqd_pkg::MARK_HUE;
            s = hbqd_pkg::MARK_SAT;
            v = hbqd_pkg::MARK_VAL;
            case ($urandom_range(2))
                0: h = h ^ (8'd1 << $urandom_range(7));
                1: s = s ^ (8'd1 << $urandom_range(7));
                default: v = v ^ (8'd1 << $urandom_range(7));
            endcase
        end else if (pick < 36) begin
            s = 8'($urandom_range(2 * hbqd_pkg::GRAY_SAT_LIMIT));
        end else if (pick < 46) begin
            h = 8'($urandom_range(170, 185));
        end
    endfunction

    // Presents one pair and returns at the edge where it is taken. On entry the
    // time step is that of the previous transfer (or of reset release), and
    // push gets exactly one assignment per step.
    task automatic send_pair(input t_hsv_pair p);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        i_hue_a <= p.hue_a;
        i_sat_a <= p.sat_a;
        i_val_a <= p.val_a;
        i_hue_b <= p.hue_b;
        i_sat_b <= p.sat_b;
        i_val_b <= p.val_b;
        do @(posedge i_clk); while (full);
        board.note_pair(p);
        pairs_sent++;
    endtask

    // Drops push and holds off until every predicted result has been popped.
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    task automatic send_random_pairs(input int unsigned count);
        t_hsv_pair p;
        repeat (count) begin
            random_pixel(p.hue_a, p.sat_a, p.val_a);
            random_pixel(p.hue_b, p.sat_b, p.val_b);
            send_pair(p);
        end
    endtask

    initial begin
        t_hsv_pair directed[$];

        // Corners of every field, gray handling, hue wrap and the marker.
        directed.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        directed.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        directed.push_back(make_pair(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
        // Don't-care marker on one side, the other side, both, and near misses.
        directed.push_back(make_pair(hbqd_pkg::MARK_HUE, hbqd_pkg::MARK_SAT,
                                     hbqd_pkg::MARK_VAL, 8'd100, 8'd200, 8'd30));
        directed.push_back(make_pair(8'd40, 8'd12, 8'd250, hbqd_pkg::MARK_HUE,
                                     hbqd_pkg::MARK_SAT, hbqd_pkg::MARK_VAL));
        directed.push_back(make_pair(hbqd_pkg::MARK_HUE, hbqd_pkg::MARK_SAT,
                                     hbqd_pkg::MARK_VAL, hbqd_pkg::MARK_HUE,
                                     hbqd_pkg::MARK_SAT, hbqd_pkg::MARK_VAL));
        directed.push_back(make_pair(8'd9, hbqd_pkg::MARK_SAT, hbqd_pkg::MARK_VAL,
                                     hbqd_pkg::MARK_HUE, hbqd_pkg::MARK_SAT, 8'd65));
        directed.push_back(make_pair(hbqd_pkg::MARK_HUE, 8'd63, hbqd_pkg::MARK_VAL,
                                     8'd136, hbqd_pkg::MARK_SAT, hbqd_pkg::MARK_VAL));
        // Saturation just below and at the gray threshold: exactly one gray.
        directed.push_back(make_pair(8'd30, 8'd9, 8'd200, 8'd30, 8'd10, 8'd200));
        // One gray pixel; the brighter value bin skips the scaling only in the first.
        directed.push_back(make_pair(8'd60, 8'd3, 8'd255, 8'd90, 8'd200, 8'd0));
        directed.push_back(make_pair(8'd90, 8'd220, 8'd150, 8'd10, 8'd0, 8'd20));
        directed.push_back(make_pair(8'd120, 8'd100, 8'd10, 8'd5, 8'd1, 8'd70));
        // Both gray with different values.
        directed.push_back(make_pair(8'd0, 8'd5, 8'd0, 8'd170, 8'd9, 8'd255));
        // Hue wrap: the top of the circle against the bottom.
        directed.push_back(make_pair(8'd175, 8'd100, 8'd100, 8'd0, 8'd100, 8'd100));
        directed.push_back(make_pair(8'd176, 8'd100, 8'd100, 8'd4, 8'd100, 8'd100));
        directed.push_back(make_pair(8'd255, 8'd150, 8'd150, 8'd180, 8'd150, 8'd150));
        directed.push_back(make_pair(8'd5, 8'd150, 8'd150, 8'd179, 8'd150, 8'd150));
        // Opposite hues with extreme saturation and value bins: largest distance.
        directed.push_back(make_pair(8'd0, 8'd10, 8'd0, 8'd90, 8'd255, 8'd255));
        // Hue differences on either side of the scaling limit.
        directed.push_back(make_pair(8'd0, 8'd64, 8'd64, 8'd18, 8'd64, 8'd64));
        directed.push_back(make_pair(8'd0, 8'd64, 8'd64, 8'd27, 8'd64, 8'd64));
        // Saturation and value bin edges.
        directed.push_back(make_pair(8'd50, 8'd63, 8'd127, 8'd50, 8'd64, 8'd128));
        directed.push_back(make_pair(8'd50, 8'd191, 8'd192, 8'd50, 8'd192, 8'd191));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: the sender idles now and then, the receiver stalls often.
        tx_idle_pct = 26;
        rx_idle_pct = 61;
        foreach (directed[i]) begin
            send_pair(directed[i]);
        end
        send_random_pairs(230);

        // Let the pipeline run dry before the flow-control settings swap.
        drain_results();

        // Phase two: a slow sender against an eager receiver.
        tx_idle_pct = 61;
        rx_idle_pct = 26;
        send_random_pairs(250);

        // Phase three: back-to-back transfers on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_pairs(250);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d results for %0d pixel pairs under three flow-control mixes.",
                 board.checked, pairs_sent);
        $display("Seen: %0d marker pixels, %0d single-gray pairs, %0d both-gray pairs.",
                 board.marker_pixels, board.single_gray_pairs, board.both_gray_pairs);
        if (board.failures == 0 && board.outstanding() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
